FILE: hw/rtl/cas_pkg.sv
// Shared types and constants for the collision avoidance steering block.
// Used by every module under hw/rtl; depends on nothing.
package cas_pkg;

  localparam int FRAC      = 16;
  localparam int CW        = 32;
  localparam int ONE       = 1 << FRAC;
  localparam int CMAX      = (2 ** (CW - 1)) - 1;
  localparam int MIN_SPEED = (ONE + 9999) / 10000;
  localparam int TENTH     = (ONE + 5) / 10;
  localparam int ADDR_W    = 4;
  localparam int QDEPTH    = 2;
  localparam int RAD_W     = 64;
  localparam int DVD_W     = 50;
  localparam int DVS_W     = 34;

  typedef enum logic {
    KIND_AGENT    = 1'b0,
    KIND_NEIGHBOR = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef struct packed {
    logic [30:0] radius;
    logic [30:0] look_ahead;
    logic [30:0] max_speed;
    logic        flat;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             sqrt_op;
    logic [RAD_W-1:0] radicand;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } dsq_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [DVD_W-1:0] result;
  } dsq_rsp_t;

endpackage

FILE: hw/rtl/cas_regs.sv
// Configuration register file behind the APB-style port.
// Depends on cas_pkg.
module cas_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cas_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output cas_pkg::cfg_t             cfg
);
  import cas_pkg::*;

  typedef enum logic [1:0] {
    REG_RADIUS     = 2'd0,
    REG_LOOK_AHEAD = 2'd1,
    REG_MAX_SPEED  = 2'd2,
    REG_FLAT       = 2'd3
  } reg_idx_t;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius     <= 31'd3276800;
      cfg.look_ahead <= 31'd65536;
      cfg.max_speed  <= 31'd39321600;
      cfg.flat       <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_RADIUS:     cfg.radius     <= pwdata[30:0];
        REG_LOOK_AHEAD: cfg.look_ahead <= pwdata[30:0];
        REG_MAX_SPEED:  cfg.max_speed  <= pwdata[30:0];
        REG_FLAT:       cfg.flat       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS:     prdata = {1'b0, cfg.radius};
      REG_LOOK_AHEAD: prdata = {1'b0, cfg.look_ahead};
      REG_MAX_SPEED:  prdata = {1'b0, cfg.max_speed};
      REG_FLAT:       prdata = {31'd0, cfg.flat};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

FILE: hw/rtl/cas_front.sv
// Input front end: takes items off the input channel and queues them.
// Depends on cas_pkg.
module cas_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  cas_pkg::item_t         item_in,
  input  logic                   pop,
  output cas_pkg::queue_out_t    qo
);
  import cas_pkg::*;

  item_t      entries [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_stall = (count == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign qo.valid = (count != 2'd0);
  assign qo.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= item_in;
        wr_ptr          <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hw/rtl/cas_dsq.sv
// Shared iterative unit: restoring divide (one quotient bit a cycle) and
// integer square root (one result bit a cycle). Depends on cas_pkg.
module cas_dsq (
  input  logic              clk,
  input  logic              rst,
  input  cas_pkg::dsq_req_t req,
  output cas_pkg::dsq_rsp_t rsp
);
  import cas_pkg::*;

  localparam int SQ_STEPS  = RAD_W / 2;
  localparam int DIV_STEPS = DVD_W;

  logic             busy;
  logic             done;
  logic             op;
  logic [5:0]       cnt;
  logic [RAD_W-1:0] x;
  logic [RAD_W-1:0] r;
  logic [RAD_W-1:0] bitv;
  logic [DVS_W:0]   rem;
  logic [DVD_W-1:0] dq;
  logic [DVS_W-1:0] dvs;

  logic [RAD_W-1:0] t;
  logic             sq_ge;
  logic [RAD_W-1:0] x_next;
  logic [RAD_W-1:0] r_next;
  logic [DVS_W:0]   rem_s;
  logic             dv_ge;
  logic [DVS_W:0]   rem_next;
  logic [DVD_W-1:0] dq_next;

  always_comb begin
    t        = r + bitv;
    sq_ge    = (x >= t);
    x_next   = sq_ge ? x - t : x;
    r_next   = sq_ge ? (r >> 1) + bitv : r >> 1;
    rem_s    = {rem[DVS_W-1:0], dq[DVD_W-1]};
    dv_ge    = (rem_s >= {1'b0, dvs});
    rem_next = dv_ge ? rem_s - {1'b0, dvs} : rem_s;
    dq_next  = {dq[DVD_W-2:0], dv_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.sqrt_op;
        cnt  <= req.sqrt_op ? 6'(SQ_STEPS - 1) : 6'(DIV_STEPS - 1);
        x    <= req.radicand;
        r    <= '0;
        bitv <= RAD_W'(1) << (RAD_W - 2);
        rem  <= '0;
        dq   <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (op) begin
          x    <= x_next;
          r    <= r_next;
          bitv <= bitv >> 2;
        end else begin
          rem <= rem_next;
          dq  <= dq_next;
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.busy   = busy;
  assign rsp.result = op ? r[DVD_W-1:0] : dq;

endmodule

FILE: hw/rtl/cas_engine.sv
// Back end: sequencer with one shared multiplier that loads the agent pose,
// scores neighbors and forms the steering result. Depends on cas_pkg.
module cas_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  cas_pkg::cfg_t             cfg,
  input  cas_pkg::queue_out_t       qo,
  output logic                      pop,
  output cas_pkg::dsq_req_t         dreq,
  input  cas_pkg::dsq_rsp_t         drsp,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        steer_x,
  output logic signed [31:0]        steer_y,
  output logic signed [31:0]        steer_z,
  output logic                      threat_found
);
  import cas_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_A_SQ, S_A_SQACC, S_A_SQRT, S_A_SQRTW, S_UD, S_UDW, S_RT_CHECK,
    S_H_SQ, S_H_ACC, S_H_SQRT, S_H_SQRTW, S_FEEL, S_FEELW, S_N_PRED, S_N_PREDW,
    S_N_PROJ, S_N_PROJW, S_N_UPD, S_FIN, S_R_FU, S_R_FUW, S_R_LU, S_R_LUW,
    S_R_TOT, S_R_TOTW, S_R_AMT, S_R_AMTW, S_R_C, S_R_CW, S_OUT
  } state_t;

  localparam logic signed [17:0] UNIT = 18'(ONE);

  function automatic logic signed [31:0] vel_of(item_t it, logic [1:0] i);
    case (i)
      2'd0:    return it.vel_x;
      2'd1:    return it.vel_y;
      default: return it.vel_z;
    endcase
  endfunction

  function automatic logic signed [31:0] pos_of(item_t it, logic [1:0] i);
    case (i)
      2'd0:    return it.pos_x;
      2'd1:    return it.pos_y;
      default: return it.pos_z;
    endcase
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? ~v + 32'd1 : v;
  endfunction

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    return v[32] ? ~v + 33'd1 : v;
  endfunction

  function automatic logic [17:0] mag18(logic signed [17:0] v);
    return v[17] ? ~v + 18'd1 : v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [48:0] v);
    if (v > $signed(49'(CMAX))) return 32'(CMAX);
    if (v < -$signed(49'(CMAX)) - 49'sd1) return -32'(CMAX) - 32'sd1;
    return v[31:0];
  endfunction

  state_t             state;
  logic [1:0]         idx;
  logic [2:0]         job;
  logic               phase;
  item_t              item;
  logic signed [31:0] apos [3];
  logic signed [17:0] fu [3];
  logic signed [17:0] ru [3];
  logic [30:0]        speed;
  logic [30:0]        feeler;
  logic signed [35:0] closest;
  logic signed [35:0] lat_keep;
  logic               have;
  logic               moving;
  logic [63:0]        sum;
  logic [31:0]        root;
  logic signed [32:0] d [3];
  logic signed [35:0] fwd_acc;
  logic signed [35:0] lat_acc;
  logic [16:0]        ufu;
  logic [16:0]        ulu;
  logic [16:0]        total;
  logic [31:0]        amount;
  logic signed [31:0] res_c [3];
  logic               res_found;
  logic [64:0]        prod;
  logic               prod_neg;

  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_neg;
  logic [64:0]        rsum;
  logic signed [47:0] qres;
  logic signed [31:0] vel_sel;
  logic signed [31:0] ud_vel;
  logic [31:0]        ud_mag;
  logic               ud_neg;
  logic [DVD_W-1:0]   ud_dvd;
  logic [16:0]        ud_q;
  logic signed [17:0] ud_val;
  logic [32:0]        three_r;
  logic [30:0]        three_r_s;
  logic signed [47:0] reach_m;
  logic signed [48:0] pr_sum;
  logic signed [31:0] pr;
  logic signed [17:0] u_sel;
  logic signed [37:0] avoid_s;
  logic signed [37:0] feeler_s;
  logic signed [37:0] f38;
  logic signed [37:0] l38;
  logic signed [37:0] lat_m;
  logic               keep;
  logic signed [35:0] lat_eff;
  logic signed [37:0] c38;
  logic signed [37:0] edge_v;
  logic signed [37:0] mc;
  logic signed [37:0] lm;
  logic               fu_div;
  logic               fu_one;
  logic [DVD_W-1:0]   fu_dvd;
  logic [DVS_W-1:0]   fu_dvs;
  logic               lu_div;
  logic signed [47:0] c_val;

  always_comb begin
    rsum    = prod + (65'd1 << (FRAC - 1));
    qres    = prod_neg ? -$signed({1'b0, rsum[FRAC+46:FRAC]})
                       : $signed({1'b0, rsum[FRAC+46:FRAC]});
    vel_sel = vel_of(item, idx);
    ud_vel  = vel_of(item, job[1:0]);
    case (job)
      3'd3: begin
        ud_mag = 32'(mag18(fu[1]));
        ud_neg = fu[1] > 18'sd0;
      end
      3'd4: begin
        ud_mag = 32'(mag18(fu[0]));
        ud_neg = fu[0][17];
      end
      default: begin
        ud_mag = mag32(ud_vel);
        ud_neg = ud_vel[31];
      end
    endcase
    ud_dvd    = (DVD_W'(ud_mag) << FRAC) + DVD_W'(root >> 1);
    ud_q      = (drsp.result > DVD_W'(ONE)) ? 17'(ONE) : drsp.result[16:0];
    ud_val    = ud_neg ? -$signed({1'b0, ud_q}) : $signed({1'b0, ud_q});
    three_r   = {2'b0, cfg.radius} + {1'b0, cfg.radius, 1'b0};
    three_r_s = (three_r > 33'(CMAX)) ? 31'(CMAX) : three_r[30:0];
    reach_m   = (qres > $signed(48'(three_r_s))) ? qres : $signed(48'(three_r_s));
    pr_sum    = 49'(pos_of(item, idx)) + 49'(qres);
    pr        = (idx == 2'd2 && cfg.flat) ? 32'sd0 : sat32(pr_sum);
    u_sel     = phase ? ru[idx] : fu[idx];
    avoid_s   = $signed({5'd0, cfg.radius, 2'b00});
    feeler_s  = $signed({7'd0, feeler});
    f38       = 38'(fwd_acc);
    l38       = 38'(lat_acc);
    lat_m     = l38[37] ? -l38 : l38;
    keep      = (f38 > -avoid_s) && (f38 - avoid_s < feeler_s) && (lat_m < avoid_s)
                && (!have || fwd_acc < closest);
    lat_eff   = (lat_keep == 36'sd0) ? 36'(TENTH) : lat_keep;
    c38       = 38'(closest);
    edge_v    = c38 - avoid_s;
    mc        = -c38;
    lm        = lat_eff[35] ? -38'(lat_eff) : 38'(lat_eff);
    fu_one    = (edge_v <= 38'sd0) && (c38 > 38'sd0);
    fu_div    = (edge_v > 38'sd0) ? (edge_v < feeler_s) : (!fu_one && mc < avoid_s);
    fu_dvd    = (edge_v > 38'sd0) ? DVD_W'(edge_v[32:0]) << FRAC
                                  : DVD_W'(mc[32:0]) << FRAC;
    fu_dvs    = (edge_v > 38'sd0) ? DVS_W'(feeler) : DVS_W'(avoid_s[32:0]);
    lu_div    = lm < avoid_s;
    c_val     = (lat_eff > 36'sd0) ? -qres : qres;
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state)
      S_A_SQ: begin
        mul_a = 33'(mag32(vel_sel));
        mul_b = mag32(vel_sel);
      end
      S_H_SQ: begin
        mul_a = 33'(mag18(fu[idx]));
        mul_b = 32'(mag18(fu[idx]));
      end
      S_FEEL: begin
        mul_a = 33'(cfg.look_ahead);
        mul_b = 32'(speed);
      end
      S_N_PRED: begin
        mul_a   = 33'(mag32(vel_sel));
        mul_b   = 32'(cfg.look_ahead);
        mul_neg = vel_sel[31];
      end
      S_N_PROJ: begin
        mul_a   = mag33(d[idx]);
        mul_b   = 32'(mag18(u_sel));
        mul_neg = d[idx][32] != u_sel[17];
      end
      S_R_TOT: begin
        mul_a = 33'(ufu);
        mul_b = 32'(ulu);
      end
      S_R_AMT: begin
        mul_a = 33'(speed);
        mul_b = 32'(total);
      end
      S_R_C: begin
        mul_a   = 33'(mag18(ru[idx]));
        mul_b   = amount;
        mul_neg = ru[idx][17];
      end
      default: ;
    endcase
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.sqrt_op  = 1'b0;
    dreq.radicand = sum;
    dreq.dividend = ud_dvd;
    dreq.divisor  = DVS_W'(root);
    case (state)
      S_A_SQRT, S_H_SQRT: begin
        dreq.start   = 1'b1;
        dreq.sqrt_op = 1'b1;
      end
      S_UD: begin
        dreq.start = (root != 32'd0);
      end
      S_R_FU: begin
        dreq.start    = fu_div;
        dreq.dividend = fu_dvd;
        dreq.divisor  = fu_dvs;
      end
      S_R_LU: begin
        dreq.start    = lu_div;
        dreq.dividend = DVD_W'(lm[32:0]) << FRAC;
        dreq.divisor  = DVS_W'(avoid_s[32:0]);
      end
      default: ;
    endcase
  end

  assign pop = (state == S_IDLE) && qo.valid;

  always_ff @(posedge clk) begin
    prod     <= 65'(mul_a) * 65'(mul_b);
    prod_neg <= mul_neg;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= 2'd0;
      job       <= 3'd0;
      phase     <= 1'b0;
      speed     <= '0;
      feeler    <= '0;
      moving    <= 1'b0;
      closest   <= 36'(CMAX);
      lat_keep  <= '0;
      have      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        apos[i] <= '0;
        fu[i]   <= '0;
        ru[i]   <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (qo.valid) begin
            item <= qo.item;
            idx  <= 2'd0;
            sum  <= '0;
            if (qo.item.kind == KIND_AGENT) begin
              closest  <= 36'(CMAX);
              lat_keep <= '0;
              have     <= 1'b0;
              state    <= S_A_SQ;
            end else if (moving) begin
              state <= S_N_PRED;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_A_SQ: state <= S_A_SQACC;
        S_A_SQACC: begin
          sum <= sum + prod[63:0];
          if (idx == 2'd2) begin
            state <= S_A_SQRT;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_A_SQ;
          end
        end
        S_A_SQRT: begin
          apos[0] <= item.pos_x;
          apos[1] <= item.pos_y;
          apos[2] <= item.pos_z;
          state   <= S_A_SQRTW;
        end
        S_A_SQRTW: begin
          if (drsp.done) begin
            root   <= drsp.result[31:0];
            speed  <= (drsp.result[31:0] > 32'(CMAX)) ? 31'(CMAX) : drsp.result[30:0];
            moving <= drsp.result[31:0] >= 32'(MIN_SPEED);
            job    <= 3'd0;
            state  <= S_UD;
          end
        end
        S_UD, S_UDW: begin
          if (state == S_UD && root != 32'd0) begin
            state <= S_UDW;
          end else if (state == S_UD || drsp.done) begin
            if (job < 3'd3) begin
              fu[job[1:0]] <= (state == S_UD) ? 18'sd0 : ud_val;
            end else begin
              ru[2'(job - 3'd3)] <= (state == S_UD) ? 18'sd0 : ud_val;
            end
            if (job == 3'd2) begin
              state <= S_RT_CHECK;
            end else if (job == 3'd4) begin
              state <= S_FEEL;
            end else begin
              job   <= job + 3'd1;
              state <= S_UD;
            end
          end
        end
        S_RT_CHECK: begin
          ru[2] <= '0;
          if (fu[0] == 18'sd0 && fu[1] == 18'sd0) begin
            ru[0] <= '0;
            if (cfg.flat || fu[2] == 18'sd0) begin
              ru[1] <= '0;
            end else begin
              ru[1] <= (fu[2] > 18'sd0) ? -UNIT : UNIT;
            end
            state <= S_FEEL;
          end else begin
            idx   <= 2'd0;
            sum   <= '0;
            state <= S_H_SQ;
          end
        end
        S_H_SQ: state <= S_H_ACC;
        S_H_ACC: begin
          sum <= sum + prod[63:0];
          if (idx == 2'd1) begin
            state <= S_H_SQRT;
          end else begin
            idx   <= 2'd1;
            state <= S_H_SQ;
          end
        end
        S_H_SQRT: state <= S_H_SQRTW;
        S_H_SQRTW: begin
          if (drsp.done) begin
            root  <= drsp.result[31:0];
            job   <= 3'd3;
            state <= S_UD;
          end
        end
        S_FEEL: begin
          if (cfg.max_speed == 31'd0) begin
            feeler <= three_r_s;
            state  <= S_FIN;
          end else begin
            state <= S_FEELW;
          end
        end
        S_FEELW: begin
          feeler <= (reach_m > 48'(CMAX)) ? 31'(CMAX) : reach_m[30:0];
          state  <= S_FIN;
        end
        S_N_PRED: state <= S_N_PREDW;
        S_N_PREDW: begin
          d[idx] <= 33'(pr) - 33'(apos[idx]);
          if (idx == 2'd2) begin
            idx     <= 2'd0;
            phase   <= 1'b0;
            fwd_acc <= '0;
            lat_acc <= '0;
            state   <= S_N_PROJ;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_N_PRED;
          end
        end
        S_N_PROJ: state <= S_N_PROJW;
        S_N_PROJW: begin
          if (phase) begin
            lat_acc <= lat_acc + 36'(qres);
          end else begin
            fwd_acc <= fwd_acc + 36'(qres);
          end
          phase <= ~phase;
          if (phase && idx == 2'd2) begin
            state <= S_N_UPD;
          end else begin
            if (phase) begin
              idx <= idx + 2'd1;
            end
            state <= S_N_PROJ;
          end
        end
        S_N_UPD: begin
          if (keep) begin
            closest  <= fwd_acc;
            lat_keep <= lat_acc;
            have     <= 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          idx <= 2'd0;
          if (!item.last) begin
            state <= S_IDLE;
          end else if (moving && have) begin
            state <= S_R_FU;
          end else begin
            res_found <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              res_c[i] <= '0;
            end
            state <= S_OUT;
          end
        end
        S_R_FU: begin
          if (fu_div) begin
            state <= S_R_FUW;
          end else begin
            ufu   <= fu_one ? 17'(ONE) : 17'd0;
            state <= S_R_LU;
          end
        end
        S_R_FUW: begin
          if (drsp.done) begin
            ufu   <= 17'(ONE) - drsp.result[16:0];
            state <= S_R_LU;
          end
        end
        S_R_LU: begin
          if (lu_div) begin
            state <= S_R_LUW;
          end else begin
            ulu   <= 17'd0;
            state <= S_R_TOT;
          end
        end
        S_R_LUW: begin
          if (drsp.done) begin
            ulu   <= 17'(ONE) - drsp.result[16:0];
            state <= S_R_TOT;
          end
        end
        S_R_TOT: state <= S_R_TOTW;
        S_R_TOTW: begin
          total <= prod[FRAC+16:FRAC];
          state <= S_R_AMT;
        end
        S_R_AMT: state <= S_R_AMTW;
        S_R_AMTW: begin
          amount <= qres[31:0];
          state  <= S_R_C;
        end
        S_R_C: state <= S_R_CW;
        S_R_CW: begin
          res_c[idx] <= sat32(49'(c_val));
          if (idx == 2'd2) begin
            res_found <= 1'b1;
            state     <= S_OUT;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_R_C;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            steer_x      <= res_c[0];
            steer_y      <= res_c[1];
            steer_z      <= res_c[2];
            threat_found <= res_found;
            closest      <= 36'(CMAX);
            lat_keep     <= '0;
            have         <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/collision_avoidance_steering_top.sv
// Top level of the collision avoidance steering block.
// Depends on cas_pkg, cas_regs, cas_front, cas_dsq and cas_engine.
//
// Usage: write agent_radius, look_ahead_time, max_speed and flat_mode
// through the APB port (byte addresses 0, 4, 8, 12) while the block is idle.
// Send one agent item (kind 0) with the agent pose, then neighbor items
// (kind 1); the item carrying last yields one result on the output channel:
// a lateral steering velocity and threat_found.
// Both channels transfer when valid is high and stall is low. A two-entry
// queue takes input items while the back end works, so the input side
// stalls only when the queue is full.
// The shared one-bit-per-cycle divide/root unit sets the time that an agent
// item and the item that ends a query take; the single shared multiplier
// sets the time that a neighbor item takes.
// A finished result waits in the output register while out_stall is high;
// the back end holds once its next result is ready, the queue keeps filling.
// Reset restores the register defaults, clears the pose and kept threat,
// and empties the queue and the output register.
module collision_avoidance_steering_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cas_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic signed [31:0]         pos_x,
  input  logic signed [31:0]         pos_y,
  input  logic signed [31:0]         pos_z,
  input  logic signed [31:0]         vel_x,
  input  logic signed [31:0]         vel_y,
  input  logic signed [31:0]         vel_z,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         steer_x,
  output logic signed [31:0]         steer_y,
  output logic signed [31:0]         steer_z,
  output logic                       threat_found
);
  import cas_pkg::*;

  cfg_t       cfg;
  item_t      item_in;
  queue_out_t qo;
  logic       pop;
  dsq_req_t   dreq;
  dsq_rsp_t   drsp;

  assign item_in.kind  = kind_t'(kind);
  assign item_in.pos_x = pos_x;
  assign item_in.pos_y = pos_y;
  assign item_in.pos_z = pos_z;
  assign item_in.vel_x = vel_x;
  assign item_in.vel_y = vel_y;
  assign item_in.vel_z = vel_z;
  assign item_in.last  = last;

  cas_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cas_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .item_in  (item_in),
    .pop      (pop),
    .qo       (qo)
  );

  cas_dsq u_dsq (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  cas_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .qo           (qo),
    .pop          (pop),
    .dreq         (dreq),
    .drsp         (drsp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .steer_x      (steer_x),
    .steer_y      (steer_y),
    .steer_z      (steer_z),
    .threat_found (threat_found)
  );

  a_no_threat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !threat_found |-> steer_x == 32'sd0 && steer_y == 32'sd0 && steer_z == 32'sd0)
    else $error("result without threat carries a nonzero vector");

  a_dsq_start_idle: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !drsp.busy)
    else $error("divide/root unit started while busy");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qo.valid)
    else $error("queue read while empty");

endmodule

FILE: bench/collision_avoidance_steering_top_tb.sv
// Testbench for collision_avoidance_steering_top: directed and random agent queries,
// checked against an in-bench fixed-point steering predictor. Depends on cas_pkg.
`timescale 1ns / 100ps
module collision_avoidance_steering_top_tb;
  import cas_pkg::*;

  localparam int REG_RADIUS = 0;
  localparam int REG_LOOK   = 1;
  localparam int REG_MAXSPD = 2;
  localparam int REG_FLAT   = 3;
  localparam longint QONE   = 64'sd65536;
  localparam longint QMAX   = 64'sd2147483647;
  localparam longint QMIN   = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE     = 1500;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic               found;
  } steer_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic kind, last, threat_found;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic signed [31:0] steer_x, steer_y, steer_z;

  collision_avoidance_steering_top DUT (.*);

  // predictor state
  longint cf_radius, cf_look, cf_maxspd, cf_flat;
  longint ag_pos[3], fwd_u[3], right_u[3];
  longint ag_speed, feeler, near_fwd, near_lat;
  bit     has_threat, ag_moving;

  steer_t steer_expected[$];
  int errors, cycles, snd_pct, rcv_pct, hold_left;

  function automatic longint sat_c(longint v);
    return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    logic [63:0] ua, ub, r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {64'd0, ua} * {64'd0, ub} + 128'd32768;
    if (p[127:80] != 0) r = 64'd1 << 62;
    else r = p[79:16];
    if (r > (64'd1 << 62)) r = 64'd1 << 62;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_ratio(longint num, logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return 0;
    q = ((num < 0 ? -num : num) * 64'd65536 + den / 2) / den;
    if (q > 64'd65536) q = 64'd65536;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint frac_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    q = 0;
    for (int i = 0; i < 16; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q[0] = 1'b1;
      end
    end
    return longint'(q);
  endfunction

  function automatic void clear_nearest();
    near_fwd = QMAX;
    near_lat = 0;
    has_threat = 0;
  endfunction

  function automatic void load_pose(longint p[3], longint v[3]);
    logic [63:0] sum, n;
    longint three_r, reach, fx, fy;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      ag_pos[i] = p[i];
      sum += (v[i] < 0 ? -v[i] : v[i]) * (v[i] < 0 ? -v[i] : v[i]);
    end
    n = int_sqrt(sum);
    ag_speed = sat_c(longint'(n));
    ag_moving = ag_speed >= MIN_SPEED;
    for (int i = 0; i < 3; i++) fwd_u[i] = unit_ratio(v[i], n);
    fx = fwd_u[0];
    fy = fwd_u[1];
    right_u[2] = 0;
    if (fx == 0 && fy == 0) begin
      right_u[0] = 0;
      right_u[1] = cf_flat != 0 ? 0 : (fwd_u[2] > 0 ? -QONE : (fwd_u[2] < 0 ? QONE : 0));
    end else begin
      n = int_sqrt(fx * fx + fy * fy);
      right_u[0] = unit_ratio(-fy, n);
      right_u[1] = unit_ratio(fx, n);
    end
    three_r = sat_c(3 * cf_radius);
    reach = cf_maxspd == 0 ? three_r : q_mul(cf_look, ag_speed);
    feeler = sat_c(reach > three_r ? reach : three_r);
    clear_nearest();
  endfunction

  function automatic void add_neighbor(longint p[3], longint v[3]);
    longint d[3], fwd, lat, avoid, pr;
    avoid = 4 * cf_radius;
    fwd = 0;
    lat = 0;
    if (!ag_moving) return;
    for (int i = 0; i < 3; i++) begin
      pr = sat_c(p[i] + q_mul(v[i], cf_look));
      if (i == 2 && cf_flat != 0) pr = 0;
      d[i] = pr - ag_pos[i];
    end
    for (int i = 0; i < 3; i++) begin
      fwd += q_mul(d[i], fwd_u[i]);
      lat += q_mul(d[i], right_u[i]);
    end
    if (fwd > -avoid && fwd - avoid < feeler && (lat < 0 ? -lat : lat) < avoid &&
        (!has_threat || fwd < near_fwd)) begin
      near_fwd = fwd;
      near_lat = lat;
      has_threat = 1;
    end
  endfunction

  function automatic steer_t finish_query();
    steer_t s;
    longint avoid, lat, edge_d, fu, lu, total, amount, c, mf, ml;
    logic [63:0] prod;
    longint st[3];
    s.found = 0;
    st = '{0, 0, 0};
    if (ag_moving && has_threat) begin
      avoid = 4 * cf_radius;
      lat = near_lat == 0 ? TENTH : near_lat;
      edge_d = near_fwd - avoid;
      mf = near_fwd < 0 ? -near_fwd : near_fwd;
      ml = lat < 0 ? -lat : lat;
      if (edge_d > 0)
        fu = edge_d >= feeler ? 0 : QONE - frac_ratio(edge_d, feeler);
      else if (near_fwd > 0)
        fu = QONE;
      else
        fu = mf >= avoid ? 0 : QONE - frac_ratio(mf, avoid);
      lu = ml >= avoid ? 0 : QONE - frac_ratio(ml, avoid);
      prod = fu * lu;
      total = longint'(prod >> 16);
      amount = q_mul(ag_speed, total);
      for (int i = 0; i < 3; i++) begin
        c = q_mul(right_u[i], amount);
        if (lat > 0) c = -c;
        st[i] = sat_c(c);
      end
      s.found = 1;
    end
    s.sx = 32'(st[0]);
    s.sy = 32'(st[1]);
    s.sz = 32'(st[2]);
    clear_nearest();
    return s;
  endfunction

  function automatic void predict_item(item_t it);
    longint p[3], v[3];
    p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
    v = '{longint'(it.vel_x), longint'(it.vel_y), longint'(it.vel_z)};
    if (it.kind == KIND_AGENT) load_pose(p, v);
    else add_neighbor(p, v);
    if (it.last) steer_expected.push_back(finish_query());
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("collision_avoidance_steering_top regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  always @(posedge clk) begin
    steer_t e;
    if (!rst && out_valid && !out_stall) begin
      if (steer_expected.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h found=%b", $time, steer_x, steer_y,
                 steer_z, threat_found);
        errors++;
      end else begin
        e = steer_expected.pop_front();
        if (steer_x !== e.sx) begin
          $display("%0t: steer_x expected %h actual %h", $time, e.sx, steer_x);
          errors++;
        end
        if (steer_y !== e.sy) begin
          $display("%0t: steer_y expected %h actual %h", $time, e.sy, steer_y);
          errors++;
        end
        if (steer_z !== e.sz) begin
          $display("%0t: steer_z expected %h actual %h", $time, e.sz, steer_z);
          errors++;
        end
        if (threat_found !== e.found) begin
          $display("%0t: threat_found expected %b actual %b", $time, e.found, threat_found);
          errors++;
        end
      end
    end
  end

  task automatic send_item(kind_t k, logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz, logic signed [31:0] vx,
                           logic signed [31:0] vy, logic signed [31:0] vz, logic lst);
    item_t it;
    while ($urandom_range(99) < snd_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    it = '{k, px, py, pz, vx, vy, vz, lst};
    kind = k;
    pos_x = px; pos_y = py; pos_z = pz;
    vel_x = vx; vel_y = vy; vel_z = vz;
    last = lst;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic wait_drained();
    in_valid = 0;
    while (steer_expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic reg_write(int idx, logic [31:0] value);
    psel = 1; pwrite = 1; penable = 0;
    paddr = ADDR_W'(idx * 4);
    pwdata = value;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_RADIUS: cf_radius = value & 32'h7FFF_FFFF;
      REG_LOOK:   cf_look   = value & 32'h7FFF_FFFF;
      REG_MAXSPD: cf_maxspd = value & 32'h7FFF_FFFF;
      default:    cf_flat   = value & 1;
    endcase
  endtask

  task automatic set_config(logic [31:0] r, logic [31:0] t, logic [31:0] m, logic f);
    wait_drained();
    reg_write(REG_RADIUS, r);
    reg_write(REG_LOOK, t);
    reg_write(REG_MAXSPD, m);
    reg_write(REG_FLAT, f);
  endtask

  function automatic logic signed [31:0] rnd_val(int span);
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  task automatic random_query(int span);
    logic signed [31:0] ax, ay, az;
    int n;
    ax = rnd_val(100 * 65536);
    ay = rnd_val(100 * 65536);
    az = rnd_val(100 * 65536);
    if ($urandom_range(9) == 0) begin
      send_item(kind_t'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, 1'($urandom_range(1)));
      return;
    end
    n = $urandom_range(8);
    send_item(KIND_AGENT, ax, ay, az, rnd_val(span), rnd_val(span), rnd_val(span), n == 0);
    for (int i = 1; i <= n; i++)
      send_item(KIND_NEIGHBOR, ax + rnd_val(300 * 65536), ay + rnd_val(300 * 65536),
                az + rnd_val(40 * 65536), rnd_val(10 * 65536), rnd_val(10 * 65536),
                rnd_val(10 * 65536), i == n && $urandom_range(11) != 0);
  endtask

  task automatic test_directed();
    send_item(KIND_NEIGHBOR, 32'sd65536, 0, 0, 0, 0, 0, 1);
    send_item(KIND_AGENT, 0, 0, 0, 32'sd655360, 0, 0, 0);
    send_item(KIND_NEIGHBOR, 32'sd327680, 0, 0, 0, 0, 0, 1);
    send_item(KIND_AGENT, 0, 0, 0, 32'sd655360, 32'sd65536, 0, 0);
    send_item(KIND_NEIGHBOR, 32'sd3276800, 32'sd655360, 0, 0, 0, 0, 0);
    send_item(KIND_NEIGHBOR, 32'sd3276800, -32'sd655360, 0, 0, 0, 0, 1);
    send_item(KIND_AGENT, 0, 0, 0, 3, 2, 1, 0);
    send_item(KIND_NEIGHBOR, 32'sd65536, 0, 0, 0, 0, 0, 1);
    send_item(KIND_AGENT, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh8000_0000, 1);
    send_item(KIND_AGENT, 0, 0, 0, 0, 0, 32'sd327680, 0);
    send_item(KIND_NEIGHBOR, 0, 32'sd65536, 32'sd655360, 0, 0, 0, 1);
    send_item(KIND_AGENT, 0, 0, 0, 32'sd655360, 0, 0, 0);
    send_item(KIND_NEIGHBOR, 32'sd655360, 32'sd131072, 0, 0, 0, 0, 0);
    send_item(KIND_AGENT, 0, 0, 0, -32'sd655360, 0, 0, 0);
    send_item(KIND_NEIGHBOR, -32'sd655360, 32'sd65536, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh7FFF_FFFF, 1);
    set_config(32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 1'b0);
    send_item(KIND_AGENT, 0, 0, 0, 0, 0, -32'sd327680, 0);
    send_item(KIND_NEIGHBOR, 0, 32'sd65536, -32'sd655360, 0, 0, 0, 1);
    send_item(KIND_AGENT, 0, 0, 0, 32'sd655360, 32'sd655360, 0, 0);
    send_item(KIND_NEIGHBOR, 32'sd655360, 0, 0, 0, 0, 0, 1);
    set_config(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_item(KIND_AGENT, 0, 0, 0, 32'sd655360, 0, 0, 0);
    send_item(KIND_NEIGHBOR, 32'sd655360, 0, 0, 0, 0, 0, 1);
    set_config(32'd3276800, 32'd65536, 32'd39321600, 1'b1);
  endtask

  task automatic test_random_phase(int sp, int rp, int queries, int span);
    snd_pct = sp;
    rcv_pct = rp;
    repeat (queries) random_query(span);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_left = 4000;
    repeat (6) random_query(20 * 65536);
    wait_drained();
  endtask

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; kind = 0; last = 0;
    pos_x = 0; pos_y = 0; pos_z = 0; vel_x = 0; vel_y = 0; vel_z = 0;
    errors = 0; cycles = 0; snd_pct = 0; rcv_pct = 0; hold_left = 0;
    cf_radius = 3276800; cf_look = 65536; cf_maxspd = 39321600; cf_flat = 1;
    for (int i = 0; i < 3; i++) begin
      ag_pos[i] = 0; fwd_u[i] = 0; right_u[i] = 0;
    end
    ag_speed = 0; feeler = 0; ag_moving = 0;
    clear_nearest();
    repeat (10) @(negedge clk);
    rst = 0;
    @(negedge clk);
    test_directed();
    test_random_phase(0, 0, 20, 20 * 65536);
    set_config(32'd1310720, 32'd131072, 32'd0, 1'b0);
    test_random_phase(56, 0, 20, 20 * 65536);
    set_config(32'd6553600, 32'd32768, 32'd65536, 1'b1);
    test_random_phase(0, 56, 20, 50 * 65536);
    set_config(32'd655360, 32'd196608, 32'h7FFF_FFFF, 1'b0);
    test_random_phase(19, 19, 20, 8 * 65536);
    set_config(32'd3276800, 32'd65536, 32'd39321600, 1'b1);
    test_random_phase(0, 0, 10, 20 * 65536);
    test_backpressure();
    if (errors == 0)
      $display("collision_avoidance_steering_top regression: pass");
    else
      $display("collision_avoidance_steering_top regression: fail");
    $finish;
  end

endmodule
